[sv/mte_pkg.sv]
// Shared widths, request mode codes and sequencer state type of the matrix transform engine.
`default_nettype none

package mte_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int MODE_W = 3;
    localparam int STEP_W = 6;
    localparam int NUM_EL = 16;

    localparam logic [MODE_W-1:0] MODE_WR_CUR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WR_OPD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POINT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_VECTOR = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

[sv/matrix_transform_engine_core.sv]
// Top level of the matrix transform engine: shared multiply-accumulate unit and its sequencer.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  mode, elem_index, elem_value, in_x..in_w
//   m_        out        m_valid / m_ready  out_x, out_y, out_z, out_w, has_w
//
// A point or vector transform issues 16 products through the one 32x32 multiplier,
// then passes a drain state and a finish state; a matrix product issues 64 products.
// The single multiplier sets the run lengths. Reset loads identity into the current
// matrix and clears the staged one. A held result does not stop a new request being
// taken; a finished point or vector transform waits in its finish state until the
// output register is free.
`default_nettype none

module matrix_transform_engine_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic        [mte_pkg::MODE_W-1:0]  s_mode,
    input  wire logic        [mte_pkg::IDX_W-1:0]   s_elem_index,
    input  wire logic signed [mte_pkg::DATA_W-1:0]  s_elem_value,
    input  wire logic signed [mte_pkg::DATA_W-1:0]  s_in_x,
    input  wire logic signed [mte_pkg::DATA_W-1:0]  s_in_y,
    input  wire logic signed [mte_pkg::DATA_W-1:0]  s_in_z,
    input  wire logic signed [mte_pkg::DATA_W-1:0]  s_in_w,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed      [mte_pkg::DATA_W-1:0]  m_out_x,
    output logic signed      [mte_pkg::DATA_W-1:0]  m_out_y,
    output logic signed      [mte_pkg::DATA_W-1:0]  m_out_z,
    output logic signed      [mte_pkg::DATA_W-1:0]  m_out_w,
    output logic                                    m_has_w
);
    import mte_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int ACC_W  = SH_W + 2;
    localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;

    state_t                    state_reg, state_next;
    logic [STEP_W-1:0]         step_reg;
    logic [MODE_W-1:0]         mode_reg;
    logic signed [DATA_W-1:0]  vec_reg [4];
    logic signed [DATA_W-1:0]  cur_reg [NUM_EL];
    logic signed [DATA_W-1:0]  opd_reg [NUM_EL];
    logic signed [DATA_W-1:0]  res_reg [NUM_EL];

    logic                      pv_reg;
    logic                      pfirst_reg;
    logic                      plast_reg;
    logic [IDX_W-1:0]          pdst_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic                      m_valid_reg;
    logic signed [DATA_W-1:0]  out_x_reg, out_y_reg, out_z_reg, out_w_reg;
    logic                      has_w_reg;

    logic                      s_fire;
    logic                      last_issue;
    logic                      out_free;
    logic [1:0]                sel_e;
    logic [1:0]                sel_r;
    logic [1:0]                sel_c;
    logic [IDX_W-1:0]          cur_idx;
    logic [IDX_W-1:0]          opd_idx;
    logic signed [DATA_W-1:0]  mul_a;
    logic signed [DATA_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_full;
    logic signed [SH_W-1:0]    prod_sh;
    logic signed [ACC_W-1:0]   acc_sum;
    logic                      in_range;
    logic signed [DATA_W-1:0]  sat_val;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign sel_e   = step_reg[1:0];
    assign sel_r   = step_reg[3:2];
    assign sel_c   = step_reg[5:4];
    assign cur_idx = {sel_e, sel_r};
    assign opd_idx = {sel_c, sel_e};

    assign last_issue = (mode_reg == MODE_MUL) ? (&step_reg) : (&step_reg[3:0]);

    assign mul_a    = cur_reg[cur_idx];
    assign mul_b    = (mode_reg == MODE_MUL) ? opd_reg[opd_idx] : vec_reg[sel_e];
    assign mul_full = mul_a * mul_b;

    assign prod_sh  = $signed(prod_reg[PROD_W-1:FRAC_BITS]);
    assign acc_sum  = (pfirst_reg ? ACC_W'(0) : acc_reg) + {{2{prod_sh[SH_W-1]}}, prod_sh};
    assign in_range = (&acc_sum[ACC_W-1:DATA_W-1]) || !(|acc_sum[ACC_W-1:DATA_W-1]);

    always_comb begin
        if (in_range) begin
            sat_val = acc_sum[DATA_W-1:0];
        end else if (acc_sum[ACC_W-1]) begin
            sat_val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_mode == MODE_MUL || s_mode == MODE_POINT
                               || s_mode == MODE_VECTOR)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (mode_reg == MODE_MUL || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and matrix stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_EL; i++) begin
                cur_reg[i] <= ((i % 5) == 0) ? FX_ONE : '0;
                opd_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            pv_reg    <= (state_reg == ST_RUN);
            if (s_fire && s_mode == MODE_WR_CUR) begin
                cur_reg[s_elem_index] <= s_elem_value;
            end
            if (s_fire && s_mode == MODE_WR_OPD) begin
                opd_reg[s_elem_index] <= s_elem_value;
            end
            if (state_reg == ST_FIN && mode_reg == MODE_MUL) begin
                for (int i = 0; i < NUM_EL; i++) begin
                    cur_reg[i] <= res_reg[i];
                end
            end
            if (state_reg == ST_FIN && mode_reg != MODE_MUL && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, multiply-accumulate datapath and result registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg   <= s_mode;
            step_reg   <= '0;
            vec_reg[0] <= s_in_x;
            vec_reg[1] <= s_in_y;
            vec_reg[2] <= s_in_z;
            vec_reg[3] <= (s_mode == MODE_POINT) ? FX_ONE : s_in_w;
        end else if (state_reg == ST_RUN) begin
            step_reg <= step_reg + STEP_W'(1);
        end

        prod_reg   <= mul_full;
        pfirst_reg <= (sel_e == 2'd0);
        plast_reg  <= (sel_e == 2'd3);
        pdst_reg   <= {sel_c, sel_r};

        if (pv_reg) begin
            acc_reg <= acc_sum;
            if (plast_reg) begin
                res_reg[pdst_reg] <= sat_val;
            end
        end

        if (state_reg == ST_FIN && mode_reg != MODE_MUL && out_free) begin
            out_x_reg <= res_reg[0];
            out_y_reg <= res_reg[1];
            out_z_reg <= res_reg[2];
            out_w_reg <= (mode_reg == MODE_VECTOR) ? res_reg[3] : '0;
            has_w_reg <= (mode_reg == MODE_VECTOR);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = out_x_reg;
    assign m_out_y = out_y_reg;
    assign m_out_z = out_z_reg;
    assign m_out_w = out_w_reg;
    assign m_has_w = has_w_reg;

endmodule

`default_nettype wire
